>>> rtl/assert_macros.svh
// Assertion macros shared by the particle identification RTL.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check that also runs while reset is held.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/cdtpid_pkg.sv
// Types and constants for the combined energy-loss / flight-time particle ID.
// No dependencies.
package cdtpid_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NSIGMA_CUT  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIGHT_CUT   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PION_LOW    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PION_HIGH   = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KAON_LOW    = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KAON_HIGH   = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTON_LOW  = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTON_HIGH = 4'd7;

  // register reset values
  localparam logic [14:0]        NSIGMA_CUT_RST  = 15'd512;
  localparam logic [14:0]        TIGHT_CUT_RST   = 15'd26;
  localparam logic signed [15:0] PION_LOW_RST    = 16'sd205;
  localparam logic signed [15:0] PION_HIGH_RST   = 16'sd1024;
  localparam logic signed [15:0] KAON_LOW_RST    = 16'sd1638;
  localparam logic signed [15:0] KAON_HIGH_RST   = 16'sd2662;
  localparam logic signed [15:0] PROTON_LOW_RST  = 16'sd3277;
  localparam logic signed [15:0] PROTON_HIGH_RST = 16'sd4710;

  // species codes
  localparam logic [1:0] SPECIES_UNKNOWN = 2'd0;
  localparam logic [1:0] SPECIES_PION    = 2'd1;
  localparam logic [1:0] SPECIES_KAON    = 2'd2;
  localparam logic [1:0] SPECIES_PROTON  = 2'd3;

  // energy-loss status codes
  localparam logic [1:0] ELOSS_ABSENT    = 2'd0;
  localparam logic [1:0] ELOSS_AMBIGUOUS = 2'd1;
  localparam logic [1:0] ELOSS_UNIQUE    = 2'd2;

  // flight status codes
  localparam logic [1:0] FLIGHT_ABSENT  = 2'd0;
  localparam logic [1:0] FLIGHT_OUTSIDE = 2'd1;
  localparam logic [1:0] FLIGHT_INSIDE  = 2'd2;

  typedef struct packed {
    logic signed [15:0] pion_eloss_sigma;
    logic signed [15:0] kaon_eloss_sigma;
    logic signed [15:0] proton_eloss_sigma;
    logic signed [15:0] pion_flight_sigma;
    logic signed [15:0] kaon_flight_sigma;
    logic signed [15:0] proton_flight_sigma;
    logic signed [15:0] eloss_value;
    logic signed [15:0] beta_value;
    logic signed [15:0] flight_mass;
  } track_t;

  typedef struct packed {
    logic [1:0] species;
    logic [1:0] eloss_status;
    logic [1:0] flight_status;
  } result_t;

endpackage

>>> rtl/combined_dedx_tof_particle_id.sv
// Top level of the combined energy-loss / flight-time particle ID.
// Uses cdtpid_pkg and assert_macros.svh.
//
// Usage:
//   track channel  (track_valid / track_ready / track): one track per item.
//   result channel (result_valid / result_ready / result): species plus the
//     energy-loss and flight status of that track, one item per track, in order.
//   cfg channel    (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//     writes, always ready outside reset; indexes past the list are dropped.
//     Write only while no track is in flight.
// From track acceptance to result, the track is registered in the input stage,
// classified by one level of compare logic, and the result is registered.
// Throughput is one track per cycle while the receiver does not stall, set by
// that single compare stage between the input and result registers.
// Reset returns all cut registers to their defaults and empties both
// stages; track_ready and cfg_ready are low while reset is held.
// When the receiver stalls the result is held, the input stage fills, and
// track_ready drops only once both stages hold an item.
`include "assert_macros.svh"

module combined_dedx_tof_particle_id
  import cdtpid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   track_valid,
  output logic                   track_ready,
  input  track_t                 track,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [14:0]        nsigma_cut;
  logic [14:0]        tight_cut;
  logic signed [15:0] win_low  [3];
  logic signed [15:0] win_high [3];

  logic    s1_valid;
  track_t  s1_track;
  logic    out_free;
  logic    s1_advance;
  result_t result_next;

  // ---------------------------------------------------------------- config
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      nsigma_cut  <= NSIGMA_CUT_RST;
      tight_cut   <= TIGHT_CUT_RST;
      win_low[0]  <= PION_LOW_RST;
      win_high[0] <= PION_HIGH_RST;
      win_low[1]  <= KAON_LOW_RST;
      win_high[1] <= KAON_HIGH_RST;
      win_low[2]  <= PROTON_LOW_RST;
      win_high[2] <= PROTON_HIGH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NSIGMA_CUT:  nsigma_cut  <= cfg_data[14:0];
        REG_TIGHT_CUT:   tight_cut   <= cfg_data[14:0];
        REG_PION_LOW:    win_low[0]  <= $signed(cfg_data);
        REG_PION_HIGH:   win_high[0] <= $signed(cfg_data);
        REG_KAON_LOW:    win_low[1]  <= $signed(cfg_data);
        REG_KAON_HIGH:   win_high[1] <= $signed(cfg_data);
        REG_PROTON_LOW:  win_low[2]  <= $signed(cfg_data);
        REG_PROTON_HIGH: win_high[2] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- handshake
  assign out_free    = !result_valid || result_ready;
  assign s1_advance  = s1_valid && out_free;
  assign track_ready = !rst && (!s1_valid || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (track_valid && track_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (track_valid && track_ready) begin
      s1_track <= track;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result <= result_next;
    end
  end

  // --------------------------------------------------------- classification
  logic signed [15:0] eloss_sig  [3];
  logic signed [15:0] flight_sig [3];
  logic [16:0]        eloss_abs  [3];
  logic [2:0]         consistent;
  logic [2:0]         above;
  logic [2:0]         unique_sp;
  logic [2:0]         in_window;
  logic [2:0]         tight_ok;
  logic [16:0]        cut_ext;
  logic [16:0]        tight_ext;
  logic signed [15:0] tight_s;
  logic               eloss_pos;
  logic               beta_pos;
  logic               both_zero;
  logic [1:0]         eloss_status;
  logic [1:0]         flight_status;
  logic [1:0]         eloss_sp;
  logic [1:0]         flight_sp;
  logic [1:0]         tight_sp;
  logic               flight_hit_unique;
  logic               flight_hit_consistent;
  logic [1:0]         species;

  assign eloss_sig[0]  = s1_track.pion_eloss_sigma;
  assign eloss_sig[1]  = s1_track.kaon_eloss_sigma;
  assign eloss_sig[2]  = s1_track.proton_eloss_sigma;
  assign flight_sig[0] = s1_track.pion_flight_sigma;
  assign flight_sig[1] = s1_track.kaon_flight_sigma;
  assign flight_sig[2] = s1_track.proton_flight_sigma;

  assign cut_ext   = {2'b00, nsigma_cut};
  assign tight_ext = {2'b00, tight_cut};
  assign tight_s   = $signed({1'b0, tight_cut});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // magnitude in 17 bits so the most negative value stays exact
      eloss_abs[i]  = eloss_sig[i][15] ? (17'd0 - {1'b1, eloss_sig[i]})
                                       : {1'b0, eloss_sig[i]};
      consistent[i] = eloss_abs[i] < cut_ext;
      above[i]      = eloss_abs[i] > cut_ext;
      in_window[i]  = (win_low[i] < s1_track.flight_mass) &&
                      (s1_track.flight_mass <= win_high[i]);
      tight_ok[i]   = (eloss_abs[i] < tight_ext) && (flight_sig[i] < tight_s);
    end
  end

  assign unique_sp[0] = consistent[0] && above[1] && above[2];
  assign unique_sp[1] = consistent[1] && above[2] && above[0];
  assign unique_sp[2] = consistent[2] && above[0] && above[1];

  assign eloss_pos = !s1_track.eloss_value[15] && (|s1_track.eloss_value);
  assign beta_pos  = !s1_track.beta_value[15] && (|s1_track.beta_value);
  assign both_zero = !(|s1_track.eloss_value) && !(|s1_track.beta_value);

  always_comb begin
    // at most one species can be unique, since the others sit above the cut
    eloss_sp = unique_sp[0] ? SPECIES_PION :
               unique_sp[1] ? SPECIES_KAON :
               unique_sp[2] ? SPECIES_PROTON : SPECIES_UNKNOWN;
    // first window wins where they overlap
    flight_sp = in_window[0] ? SPECIES_PION :
                in_window[1] ? SPECIES_KAON :
                in_window[2] ? SPECIES_PROTON : SPECIES_UNKNOWN;
    tight_sp  = tight_ok[0] ? SPECIES_PION :
                tight_ok[1] ? SPECIES_KAON :
                tight_ok[2] ? SPECIES_PROTON : SPECIES_UNKNOWN;

    if (!eloss_pos) begin
      eloss_status = ELOSS_ABSENT;
    end else if (|unique_sp) begin
      eloss_status = ELOSS_UNIQUE;
    end else begin
      eloss_status = ELOSS_AMBIGUOUS;
    end

    if (!beta_pos) begin
      flight_status = FLIGHT_ABSENT;
    end else if (|in_window) begin
      flight_status = FLIGHT_INSIDE;
    end else begin
      flight_status = FLIGHT_OUTSIDE;
    end

    flight_hit_unique     = |(unique_sp & in_window & ~(in_window << 1) & ~(in_window << 2));
    flight_hit_consistent = |(consistent & in_window & ~(in_window << 1) & ~(in_window << 2));

    species = SPECIES_UNKNOWN;
    if (eloss_status == ELOSS_UNIQUE && flight_status == FLIGHT_INSIDE) begin
      if (flight_hit_unique) begin
        species = flight_sp;
      end
    end else if (eloss_status == ELOSS_UNIQUE) begin
      if (flight_status == FLIGHT_ABSENT) begin
        species = eloss_sp;
      end
    end else if (flight_status == FLIGHT_INSIDE) begin
      if (eloss_status == ELOSS_ABSENT || flight_hit_consistent) begin
        species = flight_sp;
      end
    end else if (both_zero) begin
      species = tight_sp;
    end

    result_next.species       = species;
    result_next.eloss_status  = eloss_status;
    result_next.flight_status = flight_status;
  end

  // ------------------------------------------------------------- assertions
  `ASSERT_CLK(a_track_lands, track_valid && track_ready |=> s1_valid,
    "accepted track item did not reach the input stage")
  `ASSERT_CLK(a_stage_moves, s1_advance |=> result_valid,
    "input stage advanced without a result item")
  `ASSERT_CLK(a_species_grounded,
    result_valid && result.species != SPECIES_UNKNOWN |->
      (result.eloss_status == ELOSS_UNIQUE || result.flight_status == FLIGHT_INSIDE ||
       (result.eloss_status == ELOSS_ABSENT && result.flight_status == FLIGHT_ABSENT)),
    "species named without a unique, window or tight-cut match")
  `ASSERT_CLK_ALWAYS(a_quiet_in_reset, rst |=> !result_valid && !s1_valid,
    "pipeline not emptied by reset")

endmodule

>>> test/tb_combined_dedx_tof_particle_id.sv
// Testbench for combined_dedx_tof_particle_id: directed and random tracks checked
// against an in-bench classifier, under several cut settings and idling mixes.
// Depends on cdtpid_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_combined_dedx_tof_particle_id;
  import cdtpid_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum int {GRADE_NONE, GRADE_CONSISTENT, GRADE_UNIQUE} grade_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   track_valid = 1'b0;
  logic                   track_ready;
  track_t                 track_item = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // classifier copy of the cut registers
  logic [14:0]        band_cut = NSIGMA_CUT_RST;
  logic [14:0]        tight_band = TIGHT_CUT_RST;
  logic signed [15:0] mass_low [3] = '{PION_LOW_RST, KAON_LOW_RST, PROTON_LOW_RST};
  logic signed [15:0] mass_high [3] = '{PION_HIGH_RST, KAON_HIGH_RST, PROTON_HIGH_RST};

  result_t predicted_ids [$];
  int      mismatch_count = 0;
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  combined_dedx_tof_particle_id dut (
    .clk          (clk),
    .rst          (rst),
    .track_valid  (track_valid),
    .track_ready  (track_ready),
    .track        (track_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int magnitude(input logic signed [15:0] v);
    int s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  function automatic logic [1:0] species_code(input int i);
    case (i)
      0:       return SPECIES_PION;
      1:       return SPECIES_KAON;
      default: return SPECIES_PROTON;
    endcase
  endfunction

  function automatic result_t classify_track(input track_t t);
    int     mag [3];
    int     fsig [3];
    grade_e grade [3];
    int     eloss, beta, mass, hit, i;
    result_t r;
    mag[0] = magnitude(t.pion_eloss_sigma);
    mag[1] = magnitude(t.kaon_eloss_sigma);
    mag[2] = magnitude(t.proton_eloss_sigma);
    fsig[0] = $signed(t.pion_flight_sigma);
    fsig[1] = $signed(t.kaon_flight_sigma);
    fsig[2] = $signed(t.proton_flight_sigma);
    eloss = $signed(t.eloss_value);
    beta = $signed(t.beta_value);
    mass = $signed(t.flight_mass);
    r.species = SPECIES_UNKNOWN;
    r.eloss_status = ELOSS_ABSENT;
    r.flight_status = FLIGHT_ABSENT;
    hit = -1;
    for (i = 0; i < 3; i++) grade[i] = GRADE_NONE;

    if (eloss > 0) begin
      r.eloss_status = ELOSS_AMBIGUOUS;
      for (i = 0; i < 3; i++) begin
        if (mag[i] < int'(band_cut)) begin
          grade[i] = GRADE_CONSISTENT;
          if (mag[(i + 1) % 3] > int'(band_cut) && mag[(i + 2) % 3] > int'(band_cut)) begin
            grade[i] = GRADE_UNIQUE;
            r.eloss_status = ELOSS_UNIQUE;
          end
        end
      end
    end

    if (beta > 0) begin
      r.flight_status = FLIGHT_OUTSIDE;
      for (i = 0; i < 3; i++)
        if (hit < 0 && mass_low[i] < mass && mass <= mass_high[i]) hit = i;
      if (hit >= 0) r.flight_status = FLIGHT_INSIDE;
    end

    // scan downwards so that the first species in order wins
    if (r.eloss_status == ELOSS_UNIQUE && r.flight_status == FLIGHT_INSIDE) begin
      if (grade[hit] == GRADE_UNIQUE) r.species = species_code(hit);
    end else if (r.eloss_status == ELOSS_UNIQUE) begin
      if (r.flight_status == FLIGHT_ABSENT)
        for (i = 2; i >= 0; i--)
          if (grade[i] == GRADE_UNIQUE) r.species = species_code(i);
    end else if (r.flight_status == FLIGHT_INSIDE) begin
      if (r.eloss_status == ELOSS_ABSENT || grade[hit] == GRADE_CONSISTENT)
        r.species = species_code(hit);
    end else if (eloss == 0 && beta == 0) begin
      for (i = 2; i >= 0; i--)
        if (mag[i] < int'(tight_band) && fsig[i] < int'(tight_band))
          r.species = species_code(i);
    end
    return r;
  endfunction

  function automatic logic [15:0] any16();
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] near_value(input int centre);
    return clip16(centre - 2 + int'($urandom_range(4)));
  endfunction

  // value strictly within the band, or strictly beyond it, with a random sign
  function automatic logic signed [15:0] band_value(input bit in_band, input int cut);
    int v;
    if (in_band) begin
      if (cut == 0) return any16();
      v = int'($urandom_range(cut - 1));
    end else begin
      if (cut >= 32767 || $urandom_range(15) == 0) return 16'sh8000;
      v = cut + 1 + int'($urandom_range((32766 - cut) < 299 ? (32766 - cut) : 299));
    end
    return $urandom_range(1) ? clip16(-v) : clip16(v);
  endfunction

  function automatic logic signed [15:0] sign_value();
    case ($urandom_range(9))
      0, 1:       return 16'sd0;
      2, 3, 4, 5: return clip16(int'($urandom_range(32767, 1)));
      6, 7:       return clip16(-int'($urandom_range(32768, 1)));
      8:          return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default:    return any16();
    endcase
  endfunction

  function automatic logic signed [15:0] mass_value(input int w);
    int lo, hi;
    lo = mass_low[w];
    hi = mass_high[w];
    case ($urandom_range(4))
      0:       return any16();
      1:       return near_value(lo);
      2:       return near_value(hi);
      default: return (hi > lo) ? clip16(lo + 1 + int'($urandom_range(hi - lo - 1)))
                                : clip16(lo);
    endcase
  endfunction

  function automatic track_t random_track();
    track_t             t;
    logic signed [15:0] esig [3];
    logic signed [15:0] fsg [3];
    int                 kind, pick, i;
    kind = $urandom_range(9);
    pick = $urandom_range(2);
    for (i = 0; i < 3; i++) begin
      esig[i] = any16();
      fsg[i] = any16();
    end
    t.eloss_value = sign_value();
    t.beta_value = sign_value();
    t.flight_mass = mass_value(int'($urandom_range(2)));

    if (kind < 5) begin
      // well-formed: one species in the band, the others beyond it
      for (i = 0; i < 3; i++) esig[i] = band_value(i == pick, int'(band_cut));
      if ($urandom_range(3) != 0) t.eloss_value = clip16(int'($urandom_range(32767, 1)));
      if ($urandom_range(1)) t.flight_mass = mass_value(pick);
    end else if (kind < 7) begin
      for (i = 0; i < 3; i++)
        esig[i] = $urandom_range(1) ? near_value(int'(band_cut))
                                    : near_value(-int'(band_cut));
    end else if (kind < 9) begin
      // both detectors zero: exercise the tight cut
      t.eloss_value = 16'sd0;
      t.beta_value = 16'sd0;
      for (i = 0; i < 3; i++) begin
        esig[i] = $urandom_range(1) ? near_value(int'(tight_band))
                                    : near_value(-int'(tight_band));
        if ($urandom_range(3) != 0) fsg[i] = near_value(int'(tight_band));
      end
    end
    t.pion_eloss_sigma = esig[0];
    t.kaon_eloss_sigma = esig[1];
    t.proton_eloss_sigma = esig[2];
    t.pion_flight_sigma = fsg[0];
    t.kaon_flight_sigma = fsg[1];
    t.proton_flight_sigma = fsg[2];
    return t;
  endfunction

  function automatic track_t make_track(input int pe, ke, re, pf, kf, rf, el, bt, m);
    track_t t;
    t.pion_eloss_sigma = pe[15:0];
    t.kaon_eloss_sigma = ke[15:0];
    t.proton_eloss_sigma = re[15:0];
    t.pion_flight_sigma = pf[15:0];
    t.kaon_flight_sigma = kf[15:0];
    t.proton_flight_sigma = rf[15:0];
    t.eloss_value = el[15:0];
    t.beta_value = bt[15:0];
    t.flight_mass = m[15:0];
    return t;
  endfunction

  task automatic offer_track(input track_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      track_valid <= 1'b0;
      @(posedge clk);
    end
    track_valid <= 1'b1;
    track_item <= t;
    do @(posedge clk); while (!track_ready);
    predicted_ids.push_back(classify_track(t));
  endtask

  task automatic run_tracks(input int count);
    repeat (count) offer_track(random_track());
    track_valid <= 1'b0;
  endtask

  task automatic drain_results();
    do @(posedge clk); while (predicted_ids.size() != 0);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NSIGMA_CUT:  band_cut = data[14:0];
      REG_TIGHT_CUT:   tight_band = data[14:0];
      REG_PION_LOW:    mass_low[0] = data;
      REG_PION_HIGH:   mass_high[0] = data;
      REG_KAON_LOW:    mass_low[1] = data;
      REG_KAON_HIGH:   mass_high[1] = data;
      REG_PROTON_LOW:  mass_low[2] = data;
      REG_PROTON_HIGH: mass_high[2] = data;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] nsig, tight, lo0, hi0, lo1, hi1, lo2, hi2);
    write_reg(REG_NSIGMA_CUT, nsig);
    write_reg(REG_TIGHT_CUT, tight);
    write_reg(REG_PION_LOW, lo0);
    write_reg(REG_PION_HIGH, hi0);
    write_reg(REG_KAON_LOW, lo1);
    write_reg(REG_KAON_HIGH, hi1);
    write_reg(REG_PROTON_LOW, lo2);
    write_reg(REG_PROTON_HIGH, hi2);
    // an index past the list must change nothing
    write_reg(CFG_INDEX_W'($urandom_range(2 ** CFG_INDEX_W - 1, int'(REG_PROTON_HIGH) + 1)),
              any16());
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_settings();
    int lo [3];
    int i;
    for (i = 0; i < 3; i++) lo[i] = int'($urandom_range(12000)) - 2000;
    load_settings(16'($urandom_range(1200)), 16'($urandom_range(200)),
                  clip16(lo[0]), clip16(lo[0] + int'($urandom_range(3000))),
                  clip16(lo[1]), clip16(lo[1] + int'($urandom_range(3000))),
                  clip16(lo[2]), clip16(lo[2] + int'($urandom_range(3000))));
  endtask

  task automatic set_idling(input idle_mode_e m);
    case (m)
      IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
      default:       begin sender_idle_pct = 36; receiver_stall_pct = 36; end
    endcase
  endtask

  task automatic test_directed_defaults();
    set_idling(IDLE_NONE);
    offer_track(make_track(0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_track(make_track(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    offer_track(make_track(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768));
    offer_track(make_track(100, 1000, 1000, 0, 0, 0, 100, 0, 0));
    offer_track(make_track(-32768, -300, -32768, 0, 0, 0, 1, 0, 0));
    offer_track(make_track(600, -600, 511, 0, 0, 0, 1, 0, 0));
    // values sitting exactly on the band edge
    offer_track(make_track(512, 1000, 1000, 0, 0, 0, 1, 0, 0));
    offer_track(make_track(0, 512, 1000, 0, 0, 0, 1, 0, 0));
    // window edges: upper inclusive, lower exclusive
    offer_track(make_track(0, 0, 0, 0, 0, 0, 0, 1, 1024));
    offer_track(make_track(0, 0, 0, 0, 0, 0, 0, 1, 205));
    offer_track(make_track(0, 0, 0, 0, 0, 0, -5, 7, 1639));
    offer_track(make_track(0, 0, 0, 0, 0, 0, 1, 1, 4710));
    offer_track(make_track(10, 1000, 1000, 0, 0, 0, 1, 1, 4000));
    offer_track(make_track(1000, 10, -1000, 0, 0, 0, 7, 3, 2000));
    offer_track(make_track(10, 1000, 1000, 0, 0, 0, 1, 1, 5000));
    offer_track(make_track(1000, 1000, 1000, 0, 0, 0, 1, 1, 500));
    // both detectors zero, then one detector negative
    offer_track(make_track(30, 5, 0, 0, -100, 0, 0, 0, 0));
    offer_track(make_track(30, 30, -25, 0, 0, 25, 0, 0, 0));
    offer_track(make_track(26, 26, 26, 0, 0, 0, 0, 0, 0));
    offer_track(make_track(0, 0, 0, 26, 30000, 25, 0, 0, 0));
    offer_track(make_track(0, 0, 0, 0, 0, 0, -1, 0, 300));
    offer_track(make_track(0, 0, 0, 0, 0, 0, 0, -1, 300));
    track_valid <= 1'b0;
    drain_results();
  endtask

  task automatic test_cut_extremes();
    set_idling(IDLE_BOTH);
    // zero cuts, three full-range windows overlapping
    load_settings(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                  16'h8000, 16'h7FFF);
    run_tracks(50);
    drain_results();
    // widest cuts; empty and reversed windows
    load_settings(16'hFFFF, 16'h7FFF, 16'h0400, 16'h0400, 16'h7FFF, 16'h8000,
                  16'h1000, 16'h0FFF);
    run_tracks(50);
    drain_results();
    // partial overlaps and a negative mass window
    set_idling(IDLE_NONE);
    load_settings(16'h0100, 16'h0040, 16'h0000, 16'h07D0, 16'h03E8, 16'h0BB8,
                  16'h8000, 16'hFFFF);
    run_tracks(50);
    drain_results();
    load_settings(16'(NSIGMA_CUT_RST), 16'(TIGHT_CUT_RST), PION_LOW_RST, PION_HIGH_RST,
                  KAON_LOW_RST, KAON_HIGH_RST, PROTON_LOW_RST, PROTON_HIGH_RST);
    run_tracks(50);
    drain_results();
  endtask

  task automatic test_idle_phases();
    idle_mode_e m;
    m = m.first();
    do begin
      set_idling(m);
      repeat (2) begin
        load_random_settings();
        run_tracks(95);
        drain_results();
      end
      m = m.next();
    end while (m != m.first());
  endtask

  task automatic test_output_backpressure();
    set_idling(IDLE_NONE);
    // hold the output long enough for both stages to fill and the input to stall
    hold_left = 400;
    run_tracks(60);
    drain_results();
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (result_valid && result_ready) begin
      if (predicted_ids.size() == 0) begin
        $display("%0t: unexpected result species %0d eloss %0d flight %0d", $time,
                 result_item.species, result_item.eloss_status, result_item.flight_status);
        mismatch_count++;
      end else begin
        want = predicted_ids.pop_front();
        if (result_item.species !== want.species) begin
          $display("%0t: species expected %0d got %0d", $time, want.species,
                   result_item.species);
          mismatch_count++;
        end
        if (result_item.eloss_status !== want.eloss_status) begin
          $display("%0t: eloss_status expected %0d got %0d", $time, want.eloss_status,
                   result_item.eloss_status);
          mismatch_count++;
        end
        if (result_item.flight_status !== want.flight_status) begin
          $display("%0t: flight_status expected %0d got %0d", $time, want.flight_status,
                   result_item.flight_status);
          mismatch_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((track_valid && track_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("tb_combined_dedx_tof_particle_id NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_defaults();
    test_cut_extremes();
    test_idle_phases();
    test_output_backpressure();
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_combined_dedx_tof_particle_id OK");
    else
      $display("tb_combined_dedx_tof_particle_id NOT OK");
    $finish;
  end

endmodule
